// File: design/ompe_pkg.sv
// Shared types, constants and fixed-point helpers for the optics polynomial evaluator.
package ompe_pkg;

  localparam int unsigned ENTRIES_DEF = 256;
  localparam int unsigned PORDER_DEF  = 8;
  localparam int unsigned MAX_POW_DEF = 8;
  localparam int unsigned FRAC        = 20;
  localparam int unsigned QW          = 32;
  localparam int unsigned CNT_W       = 9;
  localparam int unsigned EXP_W       = 3;
  localparam int unsigned TAG_W       = 11;
  localparam int unsigned ACC_W       = 48;

  localparam logic [QW-1:0] ONE_Q = 32'h0010_0000;
  localparam logic [QW-1:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] Q_MIN = 32'h8000_0000;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW,
    ST_RD,
    ST_CWAIT,
    ST_HORN,
    ST_C0,
    ST_MT,
    ST_MY,
    ST_MP,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    MS_HORN = 2'd0,
    MS_T    = 2'd1,
    MS_Y    = 2'd2,
    MS_P    = 2'd3
  } msel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic  start;
    logic  pow_step;
    logic  load_tag;
    logic  horn_add;
    logic  mul;
    msel_t msel;
    logic  c0_add;
    logic  acc_add;
    logic  finish;
  } dp_cmd_t;

  function automatic logic [QW-1:0] sat_add(input logic [QW-1:0] a,
                                            input logic [QW-1:0] b);
    logic [QW:0] s;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) return s[QW] ? Q_MIN : Q_MAX;
    return s[QW-1:0];
  endfunction

  // Product of two Q20 values, floor shift, saturate.
  function automatic logic [QW-1:0] qscale(input logic signed [2*QW-1:0] p);
    logic signed [2*QW-1:0] q;
    q = p >>> FRAC;
    if (q > $signed({{QW{1'b0}}, Q_MAX})) return Q_MAX;
    if (q < $signed({{QW{1'b1}}, Q_MIN})) return Q_MIN;
    return q[QW-1:0];
  endfunction

endpackage

// File: design/optics_matrix_polynomial_eval.sv
// Optics matrix polynomial evaluator: top level.
// An evaluate transfer builds the power tables, then runs Horner steps and the t, y and p
// multiplies for each of n entries, n = active_entries capped at ENTRIES, before out_valid.
// Throughput: one evaluate at a time, the next input transfer at the earliest in the first
// out_valid cycle; a load is taken while in_stall is low. The shared multiplier sets the rate.
// Synchronous active-low reset clears control and active_entries; tables stay undefined.
module optics_matrix_polynomial_eval
  import ompe_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned PORDER  = PORDER_DEF,
  parameter int unsigned MAX_POW = MAX_POW_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_active_entries,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_command,
  input  logic [7:0]        in_entry_index,
  input  logic [1:0]        in_target_var,
  input  logic [2:0]        in_exponent_t,
  input  logic [2:0]        in_exponent_y,
  input  logic [2:0]        in_exponent_p,
  input  logic [2:0]        in_coef_index,
  input  logic signed [31:0] in_coef_value,
  input  logic signed [31:0] in_x_fp,
  input  logic signed [31:0] in_t_fp,
  input  logic signed [31:0] in_y_fp,
  input  logic signed [31:0] in_p_fp,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_delta_sum,
  output logic signed [31:0] out_theta_tan_sum,
  output logic signed [31:0] out_y_sum,
  output logic signed [31:0] out_phi_tan_sum,
  output logic              out_saturated
);
  localparam int unsigned EW  = $clog2(ENTRIES);
  localparam int unsigned CW  = $clog2(PORDER+1);
  localparam int unsigned PIW = $clog2(MAX_POW+1);

  logic [CNT_W-1:0] active_r;
  dp_cmd_t          cmd;
  logic [EW-1:0]    ent;
  logic [CW-1:0]    ci;
  logic [PIW-1:0]   pi;
  logic             ld_we;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) active_r <= '0;
    else if (cfg_valid && cfg_ready) active_r <= cfg_active_entries;
  end

  // drop loads outside the table
  assign ld_we = in_valid && !in_stall && in_command == CMD_LOAD
              && {24'd0, in_entry_index} < ENTRIES && {29'd0, in_coef_index} < PORDER;

  ompe_ctrl #(.ENTRIES(ENTRIES), .PORDER(PORDER), .MAX_POW(MAX_POW)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .active_entries(active_r),
    .out_valid(out_valid), .out_stall(out_stall),
    .cmd(cmd), .ent(ent), .ci(ci), .pi(pi)
  );

  ompe_datapath #(.ENTRIES(ENTRIES), .PORDER(PORDER), .MAX_POW(MAX_POW)) u_dp (
    .clk(clk), .cmd(cmd), .ent(ent), .ci(ci), .pi(pi),
    .ld_we(ld_we), .ld_ent(EW'(in_entry_index)), .ld_ci(CW'(in_coef_index)),
    .ld_coef(in_coef_value),
    .ld_tag({in_exponent_p, in_exponent_y, in_exponent_t, in_target_var}),
    .x_in(in_x_fp), .t_in(in_t_fp), .y_in(in_y_fp), .p_in(in_p_fp),
    .delta_sum(out_delta_sum), .theta_tan_sum(out_theta_tan_sum),
    .y_sum(out_y_sum), .phi_tan_sum(out_phi_tan_sum), .saturated(out_saturated)
  );
endmodule

// File: design/ompe_ram.sv
// Generic single-port-write, registered-read RAM.
module ompe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: design/ompe_datapath.sv
// Datapath: table memories, power tables, shared multiplier and accumulators.
module ompe_datapath
  import ompe_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned PORDER  = PORDER_DEF,
  parameter int unsigned MAX_POW = MAX_POW_DEF
) (
  input  logic                            clk,
  input  dp_cmd_t                         cmd,
  input  logic [$clog2(ENTRIES)-1:0]      ent,
  input  logic [$clog2(PORDER+1)-1:0]     ci,
  input  logic [$clog2(MAX_POW+1)-1:0]    pi,
  input  logic                            ld_we,
  input  logic [$clog2(ENTRIES)-1:0]      ld_ent,
  input  logic [$clog2(PORDER+1)-1:0]     ld_ci,
  input  logic [QW-1:0]                   ld_coef,
  input  logic [TAG_W-1:0]                ld_tag,
  input  logic [QW-1:0]                   x_in,
  input  logic [QW-1:0]                   t_in,
  input  logic [QW-1:0]                   y_in,
  input  logic [QW-1:0]                   p_in,
  output logic [QW-1:0]                   delta_sum,
  output logic [QW-1:0]                   theta_tan_sum,
  output logic [QW-1:0]                   y_sum,
  output logic [QW-1:0]                   phi_tan_sum,
  output logic                            saturated
);
  localparam int unsigned PW  = (PORDER > 1) ? $clog2(PORDER) : 1;
  localparam int unsigned CDP = ENTRIES * PORDER;
  localparam int unsigned CAW = $clog2(CDP);
  localparam int unsigned PIW = (MAX_POW > 1) ? $clog2(MAX_POW) : 1;

  logic [QW-1:0] x_r, t_r, y_r, p_r;
  logic [QW-1:0] tp_r [MAX_POW];
  logic [QW-1:0] yp_r [MAX_POW];
  logic [QW-1:0] pp_r [MAX_POW];
  logic [QW-1:0] v_r, coef_q;
  logic [TAG_W-1:0] tag_q, tag_r;
  logic signed [ACC_W-1:0] acc_r [4];
  logic [CAW-1:0] caddr_w, caddr_r;
  logic [QW-1:0] ma, mb;
  logic signed [2*QW-1:0] prod;
  logic [QW-1:0] prod_q;

  function automatic logic [PIW-1:0] pclip(input logic [EXP_W-1:0] e);
    if ({29'd0, e} > MAX_POW - 1) return PIW'(MAX_POW - 1);
    return PIW'(e);
  endfunction

  assign caddr_w = CAW'(ld_ent) * CAW'(PORDER) + CAW'(ld_ci[PW-1:0]);
  assign caddr_r = CAW'(ent) * CAW'(PORDER) + CAW'(ci[PW-1:0]);

  ompe_ram #(.WIDTH(QW), .DEPTH(CDP)) u_coef (
    .clk(clk), .we(ld_we), .waddr(caddr_w), .wdata(ld_coef),
    .raddr(caddr_r), .rdata(coef_q)
  );
  ompe_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag (
    .clk(clk), .we(ld_we), .waddr(ld_ent), .wdata(ld_tag),
    .raddr(ent), .rdata(tag_q)
  );

  // Shared multiplier operand select
  always_comb begin
    ma = v_r;
    mb = x_r;
    unique case (cmd.msel)
      MS_HORN: mb = x_r;
      MS_T:    mb = tp_r[pclip(tag_r[4:2])];
      MS_Y:    mb = yp_r[pclip(tag_r[7:5])];
      MS_P:    mb = pp_r[pclip(tag_r[10:8])];
    endcase
    if (cmd.pow_step) begin
      ma = tp_r[pi[PIW-1:0] - PIW'(1)];
      mb = t_r;
    end
  end
  assign prod   = $signed(ma) * $signed(mb);
  assign prod_q = qscale(prod);

  logic [QW-1:0] ysx, psx;
  assign ysx = qscale($signed(yp_r[pi[PIW-1:0] - PIW'(1)]) * $signed(y_r));
  assign psx = qscale($signed(pp_r[pi[PIW-1:0] - PIW'(1)]) * $signed(p_r));

  logic [QW-1:0] sx [4];
  logic [3:0]    cl;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cl[i] = 1'b0;
      sx[i] = acc_r[i][QW-1:0];
      if (acc_r[i] > $signed({{(ACC_W-QW){1'b0}}, Q_MAX})) begin
        sx[i] = Q_MAX; cl[i] = 1'b1;
      end else if (acc_r[i] < $signed({{(ACC_W-QW){1'b1}}, Q_MIN})) begin
        sx[i] = Q_MIN; cl[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r <= x_in; t_r <= t_in; y_r <= y_in; p_r <= p_in;
      tp_r[0] <= ONE_Q; yp_r[0] <= ONE_Q; pp_r[0] <= ONE_Q;
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end
    if (cmd.pow_step) begin
      tp_r[pi[PIW-1:0]] <= prod_q;
      yp_r[pi[PIW-1:0]] <= ysx;
      pp_r[pi[PIW-1:0]] <= psx;
    end
    if (cmd.load_tag) begin
      tag_r <= tag_q;
      v_r   <= '0;
    end
    if (cmd.horn_add) v_r <= sat_add(v_r, coef_q);
    if (cmd.c0_add)   v_r <= sat_add(v_r, coef_q);
    if (cmd.mul)      v_r <= prod_q;
    if (cmd.acc_add)
      acc_r[tag_r[1:0]] <= acc_r[tag_r[1:0]] + ACC_W'($signed(v_r));
    if (cmd.finish) begin
      delta_sum     <= sx[0];
      theta_tan_sum <= sx[1];
      y_sum         <= sx[2];
      phi_tan_sum   <= sx[3];
      saturated     <= |cl;
    end
  end
endmodule

// File: design/ompe_ctrl.sv
// Controller state machine sequencing powers, Horner steps and accumulation.
module ompe_ctrl
  import ompe_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF,
  parameter int unsigned PORDER  = PORDER_DEF,
  parameter int unsigned MAX_POW = MAX_POW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic [CNT_W-1:0]             active_entries,
  output logic                         out_valid,
  input  logic                         out_stall,
  output dp_cmd_t                      cmd,
  output logic [$clog2(ENTRIES)-1:0]   ent,
  output logic [$clog2(PORDER+1)-1:0]  ci,
  output logic [$clog2(MAX_POW+1)-1:0] pi
);
  localparam int unsigned EW  = $clog2(ENTRIES);
  localparam int unsigned CW  = $clog2(PORDER+1);
  localparam int unsigned PIW = $clog2(MAX_POW+1);
  localparam int unsigned NW  = $clog2(ENTRIES+1);

  state_t state_r, state_nxt;
  logic [NW-1:0]  e_r, e_nxt, n_r, n_nxt;
  logic [CW-1:0]  ci_r, ci_nxt;
  logic [PIW-1:0] pi_r, pi_nxt;
  logic           ov_r, ov_nxt;

  assign ent       = e_r[EW-1:0];
  assign ci        = ci_r;
  assign pi        = pi_r;
  assign out_valid = ov_r;
  assign in_stall  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
      e_r     <= '0;
      n_r     <= '0;
      ci_r    <= '0;
      pi_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      e_r     <= e_nxt;
      n_r     <= n_nxt;
      ci_r    <= ci_nxt;
      pi_r    <= pi_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r && out_stall;
    e_nxt     = e_r;
    n_nxt     = n_r;
    ci_nxt    = ci_r;
    pi_nxt    = pi_r;
    cmd       = '0;
    cmd.msel  = MS_HORN;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall && in_command == CMD_EVAL) begin
          cmd.start = 1'b1;
          pi_nxt    = PIW'(1);
          e_nxt     = '0;
          n_nxt     = ({23'd0, active_entries} > ENTRIES) ? NW'(ENTRIES)
                                                          : NW'(active_entries);
          state_nxt = ST_POW;
        end
      end
      ST_POW: begin
        if (pi_r >= PIW'(MAX_POW)) begin
          state_nxt = ST_RD;
        end else begin
          cmd.pow_step = 1'b1;
          pi_nxt = pi_r + PIW'(1);
        end
      end
      ST_RD: begin
        if (e_r >= n_r) begin
          state_nxt = ST_FIN;
        end else begin
          ci_nxt    = CW'(PORDER - 1);
          state_nxt = ST_CWAIT;
        end
      end
      ST_CWAIT: begin
        // tag is read out now; the highest coefficient follows next cycle
        cmd.load_tag = 1'b1;
        state_nxt = (ci_r == '0) ? ST_C0 : ST_HORN;
      end
      ST_HORN: begin
        cmd.horn_add = 1'b1;
        ci_nxt    = ci_r - CW'(1);
        state_nxt = ST_MP;
      end
      ST_MP: begin
        // multiply by x after a Horner add; or final p multiply
        cmd.mul = 1'b1;
        if (ci_r == CW'(PORDER)) begin
          cmd.msel  = MS_P;
          state_nxt = ST_ACC;
        end else begin
          cmd.msel  = MS_HORN;
          state_nxt = (ci_r == '0) ? ST_C0 : ST_HORN;
        end
      end
      ST_C0: begin
        cmd.c0_add = 1'b1;
        state_nxt = ST_MT;
      end
      ST_MT: begin
        cmd.mul = 1'b1;
        cmd.msel = MS_T;
        state_nxt = ST_MY;
      end
      ST_MY: begin
        cmd.mul = 1'b1;
        cmd.msel = MS_Y;
        ci_nxt = CW'(PORDER);
        state_nxt = ST_MP;
      end
      ST_ACC: begin
        cmd.acc_add = 1'b1;
        e_nxt     = e_r + NW'(1);
        state_nxt = ST_RD;
      end
      ST_FIN: begin
        // hold the new sums until the previous result has been taken
        if (!ov_r) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        ov_nxt    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// File: design/ompe_checker.sv
// Port-level checker bound to the top level.
module ompe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_command,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_delta_sum
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_delta_sum))
    else $error("result dropped under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_command |=> in_stall)
    else $error("evaluate transfer not blocking input");
  a_no_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_command && !out_valid |=> !out_valid)
    else $error("load produced a result");
endmodule

bind optics_matrix_polynomial_eval ompe_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .in_command(in_command), .out_valid(out_valid), .out_stall(out_stall),
  .out_delta_sum(out_delta_sum)
);
